// ===== hdl/hsw_pkg.sv =====
// shared types and constants for the hebbian synapse weight update core
package hsw_pkg;

  localparam int ACT_W  = 16;  // activation width, signed q2.14
  localparam int RATE_W = 16;  // learning rate width, unsigned q0.16
  localparam int MODE_W = 3;
  localparam int WGT_W  = 32;  // weight width, signed q16.16
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE
  } state_t;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_LEARNING_RATE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RULE_MODE      = 2'd1;
  localparam logic [CFG_AW-1:0] REG_INITIAL_WEIGHT = 2'd2;

  // learning rule codes
  localparam logic [MODE_W-1:0] MODE_HEBB       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EXPECT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXPECT_DIF = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PREVIOUS   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DIFFERENCE = 3'd4;

  // command codes
  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // reset values of the configuration registers
  localparam logic [RATE_W-1:0]        RATE_RESET = 16'd6554;
  localparam logic [MODE_W-1:0]        MODE_RESET = MODE_HEBB;
  localparam logic signed [WGT_W-1:0]  INIT_RESET = 32'sd3277;

  // expectation constants in q2.14
  localparam logic signed [16:0] ONE_Q14   = 17'sd16384;
  localparam logic signed [16:0] TENTH_Q14 = 17'sd1638;

  localparam logic signed [WGT_W-1:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [WGT_W-1:0] W_MIN = 32'sh8000_0000;

endpackage

// ===== hdl/hebbian_synapse_weight_update_core.sv =====
// top level of the hebbian synapse weight update core
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------------
//  in_      | input     | in_valid / in_stall | in_command, in_pre_activation,
//           |           |                     | in_post_activation
//  out_     | output    | out_valid/out_stall | out_new_weight
//  cfg_     | input     | cfg_wr_en           | cfg_addr, cfg_wdata
//
//  an update transaction uses one 19x19 signed multiplier three times in a row
//  (activation product, then low and high halves of that product times the
//  rate, the last pass also adding the rounding term), then the done state
//  adds the change to the weight and saturates it
//  a restart transaction goes straight to the done state
//  reset is synchronous, active low, and restores the configuration registers,
//  weight, history and output valid; a stalled result holds in the output
//  register; the core stays busy until the result register is free, and takes the next transaction right after
module hebbian_synapse_weight_update_core
  import hsw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input transactions
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic signed [ACT_W-1:0]  in_pre_activation,
  input  logic signed [ACT_W-1:0]  in_post_activation,
  // result transactions
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WGT_W-1:0]  out_new_weight,
  // configuration writes
  input  logic                     cfg_wr_en,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_DW-1:0]        cfg_wdata
);

  // configuration registers
  logic [RATE_W-1:0]        learning_rate_r;
  logic [MODE_W-1:0]        rule_mode_r;
  logic signed [WGT_W-1:0]  initial_weight_r;

  // synapse state
  logic signed [WGT_W-1:0]  weight_r;
  logic signed [ACT_W-1:0]  pre_last_r;
  logic signed [ACT_W-1:0]  pre_before_last_r;
  logic signed [ACT_W-1:0]  post_last_r;

  // captured transaction
  logic                     cmd_r;
  logic signed [ACT_W-1:0]  pre_r;
  logic signed [ACT_W-1:0]  post_r;

  // sequencer
  state_t state_r, state_nxt;

  // datapath registers
  logic signed [35:0] prod_r;   // activation product a*b
  logic signed [53:0] acc_r;    // a*b*rate plus rounding, q10.44

  // output register
  logic                     out_valid_r;
  logic signed [WGT_W-1:0]  out_new_weight_r;

  // control from the output decode
  logic mul_a_sel_op;
  logic prod_ld;
  logic acc_lo_ld;
  logic acc_hi_ld;
  logic done_fire;

  logic in_accept;
  logic out_free;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_new_weight = out_new_weight_r;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r  <= RATE_RESET;
      rule_mode_r      <= MODE_RESET;
      initial_weight_r <= INIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_LEARNING_RATE:  learning_rate_r  <= cfg_wdata[RATE_W-1:0];
        REG_RULE_MODE:      rule_mode_r      <= cfg_wdata[MODE_W-1:0];
        REG_INITIAL_WEIGHT: initial_weight_r <= $signed(cfg_wdata[WGT_W-1:0]);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- rule operands ----------------
  // expectation f(x) = min(1.0, x + 0.1) in q2.14
  logic signed [16:0] exp_sum;
  logic signed [16:0] exp_val;
  logic signed [17:0] b_expect;
  logic signed [17:0] b_diff;
  logic signed [17:0] a_diff;
  logic signed [17:0] op_a;
  logic signed [17:0] op_b;

  always_comb begin
    exp_sum  = 17'(post_last_r) + TENTH_Q14;
    exp_val  = (exp_sum < ONE_Q14) ? exp_sum : ONE_Q14;
    b_expect = 18'(post_r) - 18'(exp_val);
    b_diff   = 18'(post_r) - 18'(post_last_r);
    a_diff   = 18'(pre_last_r) - 18'(pre_before_last_r);
    case (rule_mode_r)
      MODE_HEBB: begin
        op_a = 18'(pre_r);
        op_b = 18'(post_r);
      end
      MODE_EXPECT: begin
        op_a = 18'(pre_last_r);
        op_b = b_expect;
      end
      MODE_EXPECT_DIF: begin
        op_a = a_diff;
        op_b = b_expect;
      end
      MODE_PREVIOUS: begin
        op_a = 18'(pre_last_r);
        op_b = b_diff;
      end
      MODE_DIFFERENCE: begin
        op_a = 18'(pre_r);
        op_b = b_diff;
      end
      default: begin
        // zero product gives zero change after rounding
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_command == CMD_RESTART) ? ST_DONE : ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control decode
  always_comb begin
    mul_a_sel_op = 1'b0;
    prod_ld      = 1'b0;
    acc_lo_ld    = 1'b0;
    acc_hi_ld    = 1'b0;
    done_fire    = 1'b0;
    case (state_r)
      ST_MUL1: begin
        mul_a_sel_op = 1'b1;
        prod_ld      = 1'b1;
      end
      ST_MUL2: acc_lo_ld = 1'b1;
      ST_MUL3: acc_hi_ld = 1'b1;
      ST_DONE: done_fire = out_free;
      default: ;
    endcase
  end

  // ---------------- shared multiplier ----------------
  // pass 1: a * b
  // pass 2: low 18 bits of a*b (unsigned) * rate
  // pass 3: high 18 bits of a*b (signed) * rate, weighted by 2^18
  logic signed [18:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [37:0] mul_p;

  always_comb begin
    if (mul_a_sel_op) begin
      mul_a = 19'(op_a);
      mul_b = 19'(op_b);
    end else if (acc_lo_ld) begin
      mul_a = $signed({1'b0, prod_r[17:0]});
      mul_b = $signed({3'b000, learning_rate_r});
    end else begin
      mul_a = 19'($signed(prod_r[35:18]));
      mul_b = $signed({3'b000, learning_rate_r});
    end
  end

  assign mul_p = mul_a * mul_b;

  localparam logic signed [53:0] ROUND_HALF = 54'sd134217728;  // 2^27

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_command;
      pre_r  <= in_pre_activation;
      post_r <= in_post_activation;
    end
    if (prod_ld) begin
      prod_r <= mul_p[35:0];
    end
    if (acc_lo_ld) begin
      acc_r <= $signed({19'b0, mul_p[34:0]});
    end else if (acc_hi_ld) begin
      acc_r <= acc_r + $signed({mul_p[35:0], 18'b0}) + ROUND_HALF;
    end
  end

  // ---------------- weight accumulate ----------------
  // floor of acc / 2^28 is an arithmetic shift
  logic signed [25:0] change;
  logic signed [32:0] sum_w;
  logic signed [WGT_W-1:0] sat_w;
  logic signed [WGT_W-1:0] result_w;

  always_comb begin
    change = acc_r[53:28];
    sum_w  = 33'(weight_r) + 33'(change);
    if (sum_w[32] != sum_w[31]) begin
      sat_w = sum_w[32] ? W_MIN : W_MAX;
    end else begin
      sat_w = sum_w[31:0];
    end
    result_w = (cmd_r == CMD_RESTART) ? initial_weight_r : sat_w;
  end

  // synapse state commits when the result is handed to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r          <= INIT_RESET;
      pre_last_r        <= '0;
      pre_before_last_r <= '0;
      post_last_r       <= '0;
    end else if (done_fire) begin
      weight_r <= result_w;
      if (cmd_r == CMD_RESTART) begin
        pre_last_r        <= '0;
        pre_before_last_r <= '0;
        post_last_r       <= '0;
      end else begin
        pre_before_last_r <= pre_last_r;
        pre_last_r        <= pre_r;
        post_last_r       <= post_r;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_new_weight_r <= result_w;
    end
  end

endmodule

// ===== hdl/hsw_checker.sv =====
// port-level checks for the hebbian synapse weight update core
module hsw_checker
  import hsw_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [WGT_W-1:0]  out_new_weight
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_weight))
    else $error("stalled result changed");

  // the core is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("core took no time for a transaction");

  // a new result only appears while a transaction is in flight
  a_result_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction");

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hebbian_synapse_weight_update_core hsw_checker u_hsw_checker (.*);
